### rtl/tdbt_pkg.sv
`timescale 1ns / 1ps
package tdbt_pkg;

	localparam int MAX_SOURCES    = 64;
	localparam int SOURCE_ID_BITS = 32;
	localparam int TIME_BITS      = 48;
	localparam int INDEX_BITS     = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int COUNT_BITS     = $clog2(MAX_SOURCES + 1);

	typedef enum logic [1:0] {
		REQ_ANNOUNCE = 2'd0,
		REQ_UPDATE   = 2'd1,
		REQ_WAIT     = 2'd2,
		REQ_SHIFT    = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_UNKNOWN = 2'd2
	} status_code_t;

	typedef struct packed {
		logic [1:0]                req_type;
		logic [SOURCE_ID_BITS-1:0] source_id;
		logic [TIME_BITS-1:0]      time_value;
		logic [31:0]               step_dt;
	} request_t;

	typedef struct packed {
		logic                  granted;
		logic                  woken;
		logic [1:0]            status;
		logic [COUNT_BITS-1:0] dependency_count;
		logic [TIME_BITS-1:0]  min_time;
	} result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SEARCH,
		BK_APPLY,
		BK_SHIFT,
		BK_MIN,
		BK_DONE
	} back_state_t;

endpackage

### rtl/time_dependency_barrier_table_unit.sv
`timescale 1ns / 1ps
// from acceptance to done: announce and update run a search, a write, then a min sweep;
// shift runs a saturating add pass over the entries, then a min sweep; wait runs a min sweep
// the back end works one request at a time; the two-entry queue takes new ones meanwhile
// reset: arst_n clears the queue, entry count and pending wait; key/time memories are not cleared
// the receiver cannot stall: done pulses for one cycle with the result
module time_dependency_barrier_table_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  tdbt_pkg::request_t request,
	output logic               busy,
	output logic               done,
	output tdbt_pkg::result_t  result
);
	import tdbt_pkg::*;

	// two-entry request queue between front and back
	logic     q_valid, q_pop;
	request_t q_head;

	tdbt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop)
	);

	// back end walks the table one entry per cycle through a registered read
	tdbt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.done    (done),
		.result  (result)
	);
endmodule

### rtl/tdbt_front.sv
`timescale 1ns / 1ps
// front end: takes requests, holds them in a two-entry queue
module tdbt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tdbt_pkg::request_t request,
	output logic              busy,
	output logic              q_valid,
	output tdbt_pkg::request_t q_head,
	input  logic              q_pop
);
	import tdbt_pkg::*;

	request_t   slot_q [2];
	logic       rd_ptr_q, wr_ptr_q;
	logic [1:0] fill_q;
	logic       push;

	assign busy    = (fill_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (fill_q != 2'd0);
	assign q_head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

### rtl/tdbt_back.sv
`timescale 1ns / 1ps
// back end: sequential search / shift / min sweep over the table
module tdbt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  tdbt_pkg::request_t q_head,
	output logic               q_pop,
	output logic               done,
	output tdbt_pkg::result_t  result
);
	import tdbt_pkg::*;

	localparam logic [TIME_BITS-1:0]  TMAX = '1;
	localparam logic [COUNT_BITS-1:0] CAP  = COUNT_BITS'(MAX_SOURCES);

	logic [SOURCE_ID_BITS-1:0] key_mem [MAX_SOURCES];
	logic [TIME_BITS-1:0]      time_mem [MAX_SOURCES];

	back_state_t state_q, state_d;
	request_t    req_q;
	logic [COUNT_BITS-1:0] count_q, idx_q;
	logic          found_q;
	logic [INDEX_BITS-1:0] hit_q;
	logic [TIME_BITS-1:0] hit_time_q, min_q, wait_target_q;
	logic          wait_flag_q;
	logic          granted_q, woken_q;
	logic [1:0]    status_q;

	// registered read port, one entry per cycle
	logic [SOURCE_ID_BITS-1:0] key_rd_s1;
	logic [TIME_BITS-1:0]      time_rd_s1;
	logic                      valid_s1;
	logic [INDEX_BITS-1:0]     idx_s1;

	logic [TIME_BITS-1:0]      tv_in, target, shifted;
	logic [TIME_BITS:0]        tsum, ssum;
	logic [INDEX_BITS-1:0]     idx_i;
	logic                      at_end, sweeping, issue, match, swept;

	assign tv_in    = req_q.time_value;
	assign idx_i    = idx_q[INDEX_BITS-1:0];
	assign at_end   = (idx_q >= count_q);
	assign swept    = at_end && !valid_s1;
	assign sweeping = (state_q == BK_SEARCH) || (state_q == BK_SHIFT) || (state_q == BK_MIN);
	assign issue    = sweeping && !at_end && (state_d == state_q);
	assign match    = valid_s1 && (key_rd_s1 == req_q.source_id);
	assign ssum     = {1'b0, time_rd_s1} + {1'b0, tv_in};
	assign shifted  = ssum[TIME_BITS] ? TMAX : ssum[TIME_BITS-1:0];
	assign tsum     = {1'b0, tv_in} + (TIME_BITS+1)'(req_q.step_dt);
	assign target   = tsum[TIME_BITS] ? TMAX : tsum[TIME_BITS-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (q_valid) begin
				if (q_head.req_type == REQ_SHIFT) state_d = BK_SHIFT;
				else if (q_head.req_type == REQ_WAIT) state_d = BK_MIN;
				else state_d = BK_SEARCH;
			end
			BK_SEARCH: if (match || swept) state_d = BK_APPLY;
			BK_APPLY:  state_d = BK_MIN;
			BK_SHIFT:  if (swept) state_d = BK_MIN;
			BK_MIN:    if (swept) state_d = BK_DONE;
			BK_DONE:   state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop                   = (state_q == BK_IDLE) && q_valid;
		done                    = (state_q == BK_DONE);
		result.granted          = granted_q;
		result.woken            = woken_q;
		result.status           = status_q;
		result.dependency_count = count_q;
		result.min_time         = min_q;
	end

	always_ff @(posedge clk) begin
		key_rd_s1  <= key_mem[idx_i];
		time_rd_s1 <= time_mem[idx_i];
		if (state_q == BK_APPLY) begin
			if (found_q) begin
				if (hit_time_q < tv_in) time_mem[hit_q] <= tv_in;
			end else if (req_q.req_type == REQ_ANNOUNCE && count_q < CAP) begin
				key_mem[count_q[INDEX_BITS-1:0]]  <= req_q.source_id;
				time_mem[count_q[INDEX_BITS-1:0]] <= tv_in;
			end
		end else if (state_q == BK_SHIFT && valid_s1) begin
			time_mem[idx_s1] <= shifted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BK_IDLE;
			count_q       <= '0;
			wait_flag_q   <= 1'b0;
			wait_target_q <= '0;
			req_q         <= '0;
			idx_q         <= '0;
			found_q       <= 1'b0;
			hit_q         <= '0;
			hit_time_q    <= '0;
			min_q         <= '0;
			granted_q     <= 1'b0;
			woken_q       <= 1'b0;
			status_q      <= ST_OK;
			valid_s1      <= 1'b0;
			idx_s1        <= '0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			idx_s1   <= idx_i;
			unique case (state_q)
				BK_IDLE: if (q_valid) begin
					req_q     <= q_head;
					idx_q     <= '0;
					found_q   <= 1'b0;
					granted_q <= 1'b0;
					woken_q   <= 1'b0;
					status_q  <= ST_OK;
				end
				BK_SEARCH: begin
					if (match) begin
						found_q    <= 1'b1;
						hit_q      <= idx_s1;
						hit_time_q <= time_rd_s1;
					end
					if (issue) idx_q <= idx_q + COUNT_BITS'(1);
				end
				BK_APPLY: begin
					idx_q <= '0;
					if (!found_q) begin
						if (req_q.req_type == REQ_ANNOUNCE) begin
							if (count_q < CAP) count_q <= count_q + COUNT_BITS'(1);
							else status_q <= ST_FULL;
						end else begin
							status_q <= ST_UNKNOWN;
						end
					end
				end
				BK_SHIFT: begin
					if (issue) idx_q <= idx_q + COUNT_BITS'(1);
					else if (swept) idx_q <= '0;
				end
				BK_MIN: begin
					if (issue) idx_q <= idx_q + COUNT_BITS'(1);
					if (valid_s1) begin
						if (idx_s1 == '0 || time_rd_s1 < min_q) min_q <= time_rd_s1;
					end else if (at_end) begin
						if (count_q == '0) min_q <= '0;
						if (req_q.req_type == REQ_WAIT) begin
							if (count_q == '0 || min_q >= target) begin
								granted_q     <= 1'b1;
								wait_flag_q   <= 1'b0;
								wait_target_q <= '0;
							end else begin
								wait_flag_q   <= 1'b1;
								wait_target_q <= target;
							end
						end else if (req_q.req_type == REQ_UPDATE && found_q &&
							wait_flag_q && min_q >= wait_target_q) begin
							woken_q       <= 1'b1;
							wait_flag_q   <= 1'b0;
							wait_target_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule
